// File: rtl/rpn_pkg.sv
// shared types, codes and constants for the rpn evaluator
package rpn_pkg;

	localparam int WORD_W              = 32;
	localparam int OPERAND_W           = 31;
	localparam int DEPTH_OUT_W         = 5;
	localparam int DEFAULT_STACK_DEPTH = 16;

	// input opcodes
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;
	localparam logic [2:0] OP_END  = 3'd5;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_ANSWER     = 3'd1;
	localparam logic [2:0] ST_BADOPS     = 3'd2;
	localparam logic [2:0] ST_UNEXPECTED = 3'd3;
	localparam logic [2:0] ST_DEPTH      = 3'd4;
	localparam logic [2:0] ST_DIVZERO    = 3'd5;
	localparam logic [2:0] ST_OVERFLOW   = 3'd6;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2,
		ALU_DIV = 2'd3
	} alu_op_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [2:0]           opcode;
		logic [OPERAND_W-1:0] operand_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]              status;
		logic signed [WORD_W-1:0] result_value;
		logic [DEPTH_OUT_W-1:0]  stack_depth;
	} out_item_t;

endpackage

// File: rtl/rpn_stack.sv
// operand stack memory: one write port, two registered read ports
module rpn_stack #(
	parameter int DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [rpn_pkg::WORD_W-1:0] wr_data,
	input  logic [AW-1:0]             rd_addr_a,
	input  logic [AW-1:0]             rd_addr_b,
	output logic [rpn_pkg::WORD_W-1:0] rd_data_a,
	output logic [rpn_pkg::WORD_W-1:0] rd_data_b
);

	logic [rpn_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// File: rtl/rpn_alu.sv
// shared arithmetic unit: registered add/sub/mul, bit-serial signed divide
module rpn_alu (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rpn_pkg::alu_req_t          req,
	output logic                       done,
	output logic [rpn_pkg::WORD_W-1:0] result
);

	localparam int W = rpn_pkg::WORD_W;

	typedef enum logic [2:0] {
		A_IDLE = 3'b001,
		A_DIV  = 3'b010,
		A_SIGN = 3'b100
	} alu_state_t;

	alu_state_t               state_q;
	logic [$clog2(W)-1:0]     cnt_q;
	logic [W-1:0]             rem_q;
	logic [W-1:0]             quo_q;
	logic [W-1:0]             dvs_q;
	logic                     neg_q;
	logic                     done_q;
	logic [W-1:0]             res_q;

	logic [W:0]   trial;
	logic         borrow;
	logic [W-1:0] mag_a;
	logic [W-1:0] mag_b;

	assign mag_a  = req.a[W-1] ? (W'(0) - req.a) : req.a;
	assign mag_b  = req.b[W-1] ? (W'(0) - req.b) : req.b;
	// restoring step: shift in next dividend bit, try subtracting divisor
	assign trial  = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
	assign borrow = trial[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						if (req.op == rpn_pkg::ALU_DIV) begin
							state_q <= A_DIV;
							cnt_q   <= '0;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				A_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == {$clog2(W){1'b1}}) begin
						state_q <= A_SIGN;
					end
				end
				A_SIGN: begin
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (req.start) begin
					case (req.op)
						rpn_pkg::ALU_ADD: res_q <= req.a + req.b;
						rpn_pkg::ALU_SUB: res_q <= req.a - req.b;
						rpn_pkg::ALU_MUL: res_q <= req.a * req.b;
						default: begin
							rem_q <= '0;
							quo_q <= mag_a;
							dvs_q <= mag_b;
							neg_q <= req.a[W-1] ^ req.b[W-1];
						end
					endcase
				end
			end
			A_DIV: begin
				if (borrow) begin
					rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				end else begin
					rem_q <= trial[W-1:0];
				end
				quo_q <= {quo_q[W-2:0], ~borrow};
			end
			A_SIGN: begin
				res_q <= neg_q ? (W'(0) - quo_q) : quo_q;
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: rtl/rpn_stack_evaluator_core.sv
// Reverse Polish evaluator over a bounded stack of signed 32-bit values. One token is taken
// at a time: in_ready is high only while the sequencer is idle. A push, end marker, error or
// any token seen while an error is latched is decoded with the registered stack read, then its
// result is loaded; add, subtract and multiply also pass through the shared arithmetic unit
// before the result load; divide runs in the bit-serial divider (one quotient bit per cycle,
// then sign correction and the done handoff) before the result load. Results
// sit in an output register, so a new token can be taken while the last result waits. The stack is
// a memory with two registered read ports and needs no clearing after reset.
module rpn_stack_evaluator_core #(
	parameter int STACK_DEPTH = rpn_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rpn_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rpn_pkg::out_item_t out_data
);

	localparam int W    = rpn_pkg::WORD_W;
	localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SPW  = $clog2(STACK_DEPTH + 1);
	localparam int DOW  = rpn_pkg::DEPTH_OUT_W;
	localparam int SPXW = (SPW > DOW) ? SPW : DOW;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_ALU    = 4'b0100,
		S_FINISH = 4'b1000
	} seq_state_t;

	seq_state_t         state_q;
	logic [2:0]         op_q;
	logic [W-2:0]       val_q;
	logic [SPW-1:0]     sp_q;
	logic [2:0]         err_q;
	rpn_pkg::out_item_t pend_q;
	rpn_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic [SPW-1:0]     sp_m1;
	logic [SPW-1:0]     sp_m2;
	logic [SPW-1:0]     sp_p1;
	logic [SPXW-1:0]    sp_p1_ext;
	logic [SPXW-1:0]    sp_m1_ext;
	logic [W-1:0]       top_val;
	logic [W-1:0]       below_val;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [W-1:0]       wr_data;
	rpn_pkg::alu_req_t  alu_req;
	logic               alu_done;
	logic [W-1:0]       alu_result;
	logic               in_xfer;
	logic               load_out;
	logic               is_arith;
	logic               push_ok;

	assign sp_m1     = sp_q - 1'b1;
	assign sp_m2     = sp_q - 2'd2;
	assign sp_p1     = sp_q + 1'b1;
	assign sp_p1_ext = SPXW'(sp_p1);
	assign sp_m1_ext = SPXW'(sp_m1);

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign load_out = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign is_arith = op_q inside {rpn_pkg::OP_ADD, rpn_pkg::OP_SUB,
		rpn_pkg::OP_MUL, rpn_pkg::OP_DIV};
	assign push_ok  = (op_q == rpn_pkg::OP_PUSH) && (sp_q < SPW'(STACK_DEPTH));

	rpn_stack #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(sp_m1[AW-1:0]),
		.rd_addr_b(sp_m2[AW-1:0]),
		.rd_data_a(top_val),
		.rd_data_b(below_val)
	);

	rpn_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.done  (alu_done),
		.result(alu_result)
	);

	// arithmetic is started only when the operands are known good
	always_comb begin
		alu_req.start = (state_q == S_DECODE) && (err_q == rpn_pkg::ST_OK) && is_arith &&
			(sp_q >= SPW'(2)) && !((op_q == rpn_pkg::OP_DIV) && (top_val == '0));
		alu_req.a     = below_val;
		alu_req.b     = top_val;
		case (op_q)
			rpn_pkg::OP_ADD: alu_req.op = rpn_pkg::ALU_ADD;
			rpn_pkg::OP_SUB: alu_req.op = rpn_pkg::ALU_SUB;
			rpn_pkg::OP_MUL: alu_req.op = rpn_pkg::ALU_MUL;
			default:         alu_req.op = rpn_pkg::ALU_DIV;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sp_q[AW-1:0];
		wr_data = {1'b0, val_q};
		if ((state_q == S_DECODE) && (err_q == rpn_pkg::ST_OK) && push_ok) begin
			wr_en = 1'b1;
		end else if ((state_q == S_ALU) && alu_done) begin
			wr_en   = 1'b1;
			wr_addr = sp_m2[AW-1:0];
			wr_data = alu_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q    <= '0;
			err_q   <= rpn_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_FINISH;
					if (err_q != rpn_pkg::ST_OK) begin
						sp_q <= '0;
						if (op_q == rpn_pkg::OP_END) begin
							err_q <= rpn_pkg::ST_OK;
						end
					end else if (op_q == rpn_pkg::OP_PUSH) begin
						if (push_ok) begin
							sp_q <= sp_p1;
						end else begin
							sp_q  <= '0;
							err_q <= rpn_pkg::ST_OVERFLOW;
						end
					end else if (is_arith) begin
						if (sp_q < SPW'(2)) begin
							sp_q  <= '0;
							err_q <= rpn_pkg::ST_BADOPS;
						end else if ((op_q == rpn_pkg::OP_DIV) && (top_val == '0)) begin
							sp_q  <= '0;
							err_q <= rpn_pkg::ST_DIVZERO;
						end else begin
							state_q <= S_ALU;
						end
					end else if (op_q == rpn_pkg::OP_END) begin
						sp_q <= '0;
					end else begin
						sp_q  <= '0;
						err_q <= rpn_pkg::ST_UNEXPECTED;
					end
				end
				S_ALU: begin
					if (alu_done) begin
						sp_q    <= sp_m1;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// token capture and pending result
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= in_data.opcode;
			val_q <= in_data.operand_value;
		end
		if (state_q == S_DECODE) begin
			pend_q.result_value <= '0;
			pend_q.stack_depth  <= '0;
			if (err_q != rpn_pkg::ST_OK) begin
				pend_q.status <= err_q;
			end else if (op_q == rpn_pkg::OP_PUSH) begin
				if (push_ok) begin
					pend_q.status       <= rpn_pkg::ST_OK;
					pend_q.result_value <= {1'b0, val_q};
					pend_q.stack_depth  <= sp_p1_ext[DOW-1:0];
				end else begin
					pend_q.status <= rpn_pkg::ST_OVERFLOW;
				end
			end else if (is_arith) begin
				if (sp_q < SPW'(2)) begin
					pend_q.status <= rpn_pkg::ST_BADOPS;
				end else begin
					pend_q.status <= rpn_pkg::ST_DIVZERO;
				end
			end else if (op_q == rpn_pkg::OP_END) begin
				if (sp_q == SPW'(1)) begin
					pend_q.status       <= rpn_pkg::ST_ANSWER;
					pend_q.result_value <= top_val;
				end else begin
					pend_q.status <= rpn_pkg::ST_DEPTH;
				end
			end else begin
				pend_q.status <= rpn_pkg::ST_UNEXPECTED;
			end
		end else if ((state_q == S_ALU) && alu_done) begin
			pend_q.status       <= rpn_pkg::ST_OK;
			pend_q.result_value <= alu_result;
			pend_q.stack_depth  <= sp_m1_ext[DOW-1:0];
		end
		if (load_out) begin
			out_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: verif/tb.sv
// testbench for the rpn stack evaluator core: queued token driver, ready stalls, predictor checks
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_W = rpn_pkg::WORD_W;
	localparam int OPERAND_W = rpn_pkg::OPERAND_W;
	localparam int DEPTH_OUT_W = rpn_pkg::DEPTH_OUT_W;
	localparam int STACK_N = rpn_pkg::DEFAULT_STACK_DEPTH;
	localparam int TOKEN_TARGET = 1150;
	localparam int TAIL_TOKENS = 100;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [OPERAND_W-1:0] OPND_MAX = '1;
	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rpn_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rpn_pkg::out_item_t out_data;

	rpn_pkg::in_item_t token_q[$];
	rpn_pkg::out_item_t results_due[$];

	// predictor state
	logic [WORD_W-1:0] stack_mem[STACK_N];
	int unsigned stack_fill = 0;
	logic [2:0] err_latch = rpn_pkg::ST_OK;

	bit in_taken = 1'b0;
	bit quiet = 1'b0;
	int in_gap = 0;
	int out_stall = 0;
	int idle_pct = 10;
	int tokens_taken = 0;
	int fault_count = 0;
	rpn_pkg::out_item_t due;

	rpn_stack_evaluator_core #(
		.STACK_DEPTH(STACK_N)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rpn_pkg::out_item_t raise_error(logic [2:0] code);
		rpn_pkg::out_item_t res;
		res = '0;
		res.status = code;
		stack_fill = 0;
		err_latch = code;
		return res;
	endfunction

	function automatic rpn_pkg::out_item_t eval_token(rpn_pkg::in_item_t tok);
		rpn_pkg::out_item_t res;
		logic [WORD_W-1:0] lhs, rhs, mag_l, mag_r, quo, val;
		res = '0;
		val = '0;
		// a latched error swallows tokens until the end marker
		if (err_latch != rpn_pkg::ST_OK) begin
			res.status = err_latch;
			stack_fill = 0;
			if (tok.opcode == rpn_pkg::OP_END)
				err_latch = rpn_pkg::ST_OK;
			return res;
		end
		case (tok.opcode)
			rpn_pkg::OP_PUSH: begin
				if (stack_fill >= STACK_N)
					return raise_error(rpn_pkg::ST_OVERFLOW);
				val = {1'b0, tok.operand_value};
				stack_mem[stack_fill] = val;
				stack_fill++;
			end
			rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
				if (stack_fill < 2)
					return raise_error(rpn_pkg::ST_BADOPS);
				rhs = stack_mem[stack_fill - 1];
				lhs = stack_mem[stack_fill - 2];
				case (tok.opcode)
					rpn_pkg::OP_ADD: val = lhs + rhs;
					rpn_pkg::OP_SUB: val = lhs - rhs;
					rpn_pkg::OP_MUL: val = lhs * rhs;
					default: begin
						if (rhs == '0)
							return raise_error(rpn_pkg::ST_DIVZERO);
						// truncate toward zero on magnitudes, then fix the sign
						mag_l = lhs[WORD_W-1] ? -lhs : lhs;
						mag_r = rhs[WORD_W-1] ? -rhs : rhs;
						quo = mag_l / mag_r;
						val = (lhs[WORD_W-1] ^ rhs[WORD_W-1]) ? -quo : quo;
					end
				endcase
				stack_fill--;
				stack_mem[stack_fill - 1] = val;
			end
			rpn_pkg::OP_END: begin
				res.status = (stack_fill == 1) ? rpn_pkg::ST_ANSWER : rpn_pkg::ST_DEPTH;
				res.result_value = (stack_fill == 1) ? stack_mem[0] : '0;
				stack_fill = 0;
				return res;
			end
			default: return raise_error(rpn_pkg::ST_UNEXPECTED);
		endcase
		res.status = rpn_pkg::ST_OK;
		res.result_value = val;
		res.stack_depth = stack_fill[DEPTH_OUT_W-1:0];
		return res;
	endfunction

	task automatic check_field(string name, logic signed [WORD_W-1:0] want,
			logic signed [WORD_W-1:0] got);
		if (got !== want) begin
			fault_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	task automatic send(logic [2:0] op, logic [OPERAND_W-1:0] val);
		rpn_pkg::in_item_t tok;
		tok.opcode = op;
		tok.operand_value = val;
		token_q.push_back(tok);
	endtask

	function automatic logic [OPERAND_W-1:0] pick_operand();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return OPERAND_W'(1);
			2: return OPND_MAX;
			3, 4: return OPERAND_W'($urandom_range(0, 100));
			default: return OPERAND_W'($urandom());
		endcase
	endfunction

	// well-formed expression with random operands and operators
	task automatic gen_expression();
		int pushes_left;
		int depth;
		pushes_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, STACK_N) :
			$urandom_range(1, 6);
		depth = 0;
		while (pushes_left > 0 || depth > 1) begin
			if (depth >= 2 && (pushes_left == 0 || $urandom_range(0, 2) == 0)) begin
				send(3'($urandom_range(rpn_pkg::OP_ADD, rpn_pkg::OP_DIV)), pick_operand());
				depth--;
			end else begin
				send(rpn_pkg::OP_PUSH, pick_operand());
				depth++;
				pushes_left--;
			end
		end
		send(rpn_pkg::OP_END, pick_operand());
	endtask

	task automatic gen_broken();
		int n;
		case ($urandom_range(0, 3))
			0: begin
				// fill the stack, then one push too many
				repeat (STACK_N + 1) send(rpn_pkg::OP_PUSH, pick_operand());
				n = $urandom_range(0, 3);
				repeat (n) send(3'($urandom_range(0, 7)), pick_operand());
			end
			1: begin
				n = $urandom_range(0, 4);
				if (n == 1)
					n = 2;
				repeat (n) send(rpn_pkg::OP_PUSH, pick_operand());
			end
			2: begin
				n = $urandom_range(0, 1);
				repeat (n) send(rpn_pkg::OP_PUSH, pick_operand());
				send(3'($urandom_range(rpn_pkg::OP_ADD, rpn_pkg::OP_DIV)), pick_operand());
			end
			default: begin
				n = $urandom_range(1, 6);
				repeat (n) send(3'($urandom_range(0, 7)), OPERAND_W'($urandom()));
			end
		endcase
		send(rpn_pkg::OP_END, pick_operand());
	endtask

	// driver: inputs move on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			quiet = (token_q.size() < TAIL_TOKENS);
			if (!in_valid || in_taken) begin
				if (in_gap == 0 && !quiet && token_q.size() != 0 &&
						$urandom_range(0, 99) < idle_pct)
					in_gap = $urandom_range(1, 12);
				if (in_gap != 0 || token_q.size() == 0) begin
					in_valid <= 1'b0;
					if (in_gap != 0)
						in_gap--;
				end else begin
					in_data <= token_q.pop_front();
					in_valid <= 1'b1;
				end
			end
			in_taken = 1'b0;

			if (out_stall == 0 && !quiet && $urandom_range(0, 99) < idle_pct / 2)
				out_stall = $urandom_range(1, 12);
			if (out_stall != 0) begin
				out_ready <= 1'b0;
				out_stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: both transfers seen on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				results_due.push_back(eval_token(in_data));
				in_taken = 1'b1;
				tokens_taken++;
				// switch idling intensity now and then, including none at all
				if (tokens_taken % 64 == 0) begin
					case ($urandom_range(0, 2))
						0: idle_pct = 0;
						1: idle_pct = 10;
						default: idle_pct = 35;
					endcase
				end
			end
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					fault_count++;
					$error("result transfer with nothing expected");
				end else begin
					due = results_due.pop_front();
					check_field("status", WORD_W'(due.status), WORD_W'(out_data.status));
					check_field("result_value", due.result_value, out_data.result_value);
					check_field("stack_depth", WORD_W'(due.stack_depth),
						WORD_W'(out_data.stack_depth));
				end
			end
		end
	end

	initial begin
		// wrapping add and multiply
		send(rpn_pkg::OP_PUSH, OPND_MAX);
		send(rpn_pkg::OP_PUSH, OPND_MAX);
		send(rpn_pkg::OP_MUL, '0);
		send(rpn_pkg::OP_PUSH, OPND_MAX);
		send(rpn_pkg::OP_ADD, OPND_MAX);
		send(rpn_pkg::OP_END, '0);
		// build the most negative value and divide it by minus one
		send(rpn_pkg::OP_PUSH, '0);
		send(rpn_pkg::OP_PUSH, OPND_MAX);
		send(rpn_pkg::OP_SUB, '0);
		send(rpn_pkg::OP_PUSH, OPERAND_W'(1));
		send(rpn_pkg::OP_SUB, '0);
		send(rpn_pkg::OP_PUSH, '0);
		send(rpn_pkg::OP_PUSH, OPERAND_W'(1));
		send(rpn_pkg::OP_SUB, '0);
		send(rpn_pkg::OP_DIV, '0);
		send(rpn_pkg::OP_END, '0);
		// divide by zero, then a token while latched, then the clearing end
		send(rpn_pkg::OP_PUSH, OPERAND_W'(1));
		send(rpn_pkg::OP_PUSH, '0);
		send(rpn_pkg::OP_DIV, '0);
		send(rpn_pkg::OP_PUSH, OPERAND_W'(5));
		send(rpn_pkg::OP_END, '0);
		// too few operands
		send(rpn_pkg::OP_ADD, '0);
		send(rpn_pkg::OP_END, '0);
		// unexpected tokens
		send(OP_BAD6, OPND_MAX);
		send(OP_BAD7, '0);
		send(rpn_pkg::OP_END, '0);
		// end with an empty stack
		send(rpn_pkg::OP_END, OPND_MAX);

		while (token_q.size() < TOKEN_TARGET) begin
			if ($urandom_range(0, 4) == 0)
				gen_broken();
			else
				gen_expression();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (token_q.size() != 0 || in_valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
